FILE: sv/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned DIV_W = 32;
  localparam logic [10:0] MAX_SAMPLES = 11'd1024;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;

  localparam logic [31:0] K_NEG_7357 = 32'd0 - 32'd7357;

  // Calibration words, each widened to 32 bits (signed ones sign-extended)
  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
  } cal_t;

  // Context that rides along with a divide
  typedef struct packed {
    logic [31:0] val;
    logic        flag;
    logic        err;
  } side_t;

  // Signed divide by 2^k, truncating toward zero
  function automatic logic [31:0] sdiv_p2(input logic [31:0] a, input logic [4:0] k);
    logic [31:0] mask;
    logic [31:0] s;
    mask = (32'd1 << k) - 32'd1;
    s = a + (a[31] ? mask : 32'd0);
    return $signed(s) >>> k;
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] a);
    return a[31] ? (32'd0 - a) : a;
  endfunction

endpackage

FILE: sv/bpc_div.sv
module bpc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_v,
  input  logic [31:0]        num,
  input  logic [31:0]        den,
  input  bpc_pkg::side_t     side_in,
  output logic               out_v,
  output logic [31:0]        quot,
  output bpc_pkg::side_t     side_out
);

  localparam int unsigned N = bpc_pkg::DIV_W;

  logic [N-1:0]   v;
  logic [31:0]    nq [N];
  logic [31:0]    rem [N];
  logic [31:0]    dq [N];
  bpc_pkg::side_t sd [N];

  logic [31:0]    nq_next [N];
  logic [31:0]    rem_next [N];

  // One restoring step per stage; the quotient shifts into the numerator word
  always_comb begin
    logic [31:0] sn;
    logic [31:0] sr;
    logic [31:0] sdv;
    logic [32:0] cur;
    logic [32:0] trial;
    for (int i = 0; i < N; i++) begin
      sn  = (i == 0) ? num : nq[(i == 0) ? 0 : i - 1];
      sr  = (i == 0) ? 32'd0 : rem[(i == 0) ? 0 : i - 1];
      sdv = (i == 0) ? den : dq[(i == 0) ? 0 : i - 1];
      cur = {sr, sn[31]};
      trial = cur - {1'b0, sdv};
      if (!trial[32]) begin
        rem_next[i] = trial[31:0];
        nq_next[i]  = {sn[30:0], 1'b1};
      end else begin
        rem_next[i] = cur[31:0];
        nq_next[i]  = {sn[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[N-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < N; i++) begin
        nq[i]  <= nq_next[i];
        rem[i] <= rem_next[i];
      end
      dq[0] <= den;
      sd[0] <= side_in;
      for (int i = 1; i < N; i++) begin
        dq[i] <= dq[i-1];
        sd[i] <= sd[i-1];
      end
    end
  end

  assign out_v    = v[N-1];
  assign quot     = nq[N-1];
  assign side_out = sd[N-1];

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    v[N-1] && dq[N-1] != 32'd0 |-> rem[N-1] < dq[N-1])
    else $error("divider remainder not below divisor");

endmodule

FILE: sv/bpc_coef.sv
module bpc_coef (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  bpc_pkg::cal_t   cal,
  input  logic            in_v,
  input  logic [31:0]     q1,
  input  bpc_pkg::side_t  side1,
  input  logic [31:0]     up,
  output logic            out_v,
  output logic [31:0]     num2,
  output logic [31:0]     den2,
  output bpc_pkg::side_t  side2
);

  logic [9:0] v;

  logic [31:0] c1_b5, c1_up;
  logic        c1_err;
  logic [31:0] c2_t, c2_b6, c2_up;
  logic        c2_err;
  logic [31:0] c3_t, c3_sq, c3_a2, c3_a3, c3_up;
  logic        c3_err;
  logic [31:0] c4_t, c4_sq, c4_x2, c4_x1c, c4_up;
  logic        c4_err;
  logic [31:0] c5_t, c5_mb2, c5_mb1, c5_x2, c5_x1c, c5_up;
  logic        c5_err;
  logic [31:0] c6_t, c6_x3, c6_s, c6_up;
  logic        c6_err;
  logic [31:0] c7_t, c7_b3, c7_x3c, c7_up;
  logic        c7_err;
  logic [31:0] c8_t, c8_m4, c8_diff;
  logic        c8_err;
  logic [31:0] c9_t, c9_b4, c9_b7;
  logic        c9_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[8:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // B5 from the temperature quotient
      c1_b5  <= side1.val + (side1.flag ? (32'd0 - q1) : q1);
      c1_up  <= up;
      c1_err <= side1.err;
      // temperature and B6
      c2_t   <= bpc_pkg::sdiv_p2(c1_b5 + 32'd8, 5'd4);
      c2_b6  <= c1_b5 - 32'd4000;
      c2_up  <= c1_up;
      c2_err <= c1_err;
      // first products on B6
      c3_t   <= c2_t;
      c3_sq  <= c2_b6 * c2_b6;
      c3_a2  <= cal.ac2 * c2_b6;
      c3_a3  <= cal.ac3 * c2_b6;
      c3_up  <= c2_up;
      c3_err <= c2_err;
      c4_t   <= c3_t;
      c4_sq  <= bpc_pkg::sdiv_p2(c3_sq, 5'd12);
      c4_x2  <= bpc_pkg::sdiv_p2(c3_a2, 5'd11);
      c4_x1c <= bpc_pkg::sdiv_p2(c3_a3, 5'd13);
      c4_up  <= c3_up;
      c4_err <= c3_err;
      // products on B6 squared
      c5_t   <= c4_t;
      c5_mb2 <= cal.b2 * c4_sq;
      c5_mb1 <= cal.b1 * c4_sq;
      c5_x2  <= c4_x2;
      c5_x1c <= c4_x1c;
      c5_up  <= c4_up;
      c5_err <= c4_err;
      c6_t   <= c5_t;
      c6_x3  <= bpc_pkg::sdiv_p2(c5_mb2, 5'd11) + c5_x2;
      c6_s   <= c5_x1c + bpc_pkg::sdiv_p2(c5_mb1, 5'd16) + 32'd2;
      c6_up  <= c5_up;
      c6_err <= c5_err;
      // B3 and the B4 term
      c7_t   <= c6_t;
      c7_b3  <= bpc_pkg::sdiv_p2({cal.ac1[29:0], 2'b00} + c6_x3 + 32'd2, 5'd2);
      c7_x3c <= bpc_pkg::sdiv_p2(c6_s, 5'd2);
      c7_up  <= c6_up;
      c7_err <= c6_err;
      c8_t    <= c7_t;
      c8_m4   <= cal.ac4 * (c7_x3c + 32'd32768);
      c8_diff <= c7_up - c7_b3;
      c8_err  <= c7_err;
      c9_t   <= c8_t;
      c9_b4  <= {15'd0, c8_m4[31:15]};
      c9_b7  <= c8_diff * 32'd50000;
      c9_err <= c8_err;
      // pick the divide form that keeps B7 in range
      den2       <= c9_b4;
      num2       <= c9_b7[31] ? c9_b7 : {c9_b7[30:0], 1'b0};
      side2.val  <= c9_t;
      side2.flag <= c9_b7[31];
      side2.err  <= c9_err | (c9_b4 == 32'd0);
    end
  end

  assign out_v = v[9];

  a_b4_err: assert property (@(posedge clk) disable iff (rst)
    adv && v[8] && c9_b4 == 32'd0 |=> side2.err)
    else $error("zero B4 not flagged");

endmodule

FILE: sv/bpc_poly.sv
module bpc_poly (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_v,
  input  logic [31:0]        q2,
  input  bpc_pkg::side_t     side2,
  output logic               out_v,
  output logic signed [31:0] temperature,
  output logic signed [31:0] pressure,
  output logic               divide_error
);

  logic [5:0] v;

  logic [31:0] p1_p, p1_t;
  logic        p1_err;
  logic [31:0] p2_p, p2_t, p2_q8, p2_mn;
  logic        p2_err;
  logic [31:0] p3_p, p3_t, p3_qq, p3_x2;
  logic        p3_err;
  logic [31:0] p4_p, p4_t, p4_m3, p4_x2;
  logic        p4_err;
  logic [31:0] p5_p, p5_t, p5_s;
  logic        p5_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[4:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_p   <= side2.flag ? {q2[30:0], 1'b0} : q2;
      p1_t   <= side2.val;
      p1_err <= side2.err;
      p2_p   <= p1_p;
      p2_t   <= p1_t;
      p2_q8  <= bpc_pkg::sdiv_p2(p1_p, 5'd8);
      p2_mn  <= bpc_pkg::K_NEG_7357 * p1_p;
      p2_err <= p1_err;
      p3_p   <= p2_p;
      p3_t   <= p2_t;
      p3_qq  <= p2_q8 * p2_q8;
      p3_x2  <= bpc_pkg::sdiv_p2(p2_mn, 5'd16);
      p3_err <= p2_err;
      p4_p   <= p3_p;
      p4_t   <= p3_t;
      p4_m3  <= p3_qq * 32'd3038;
      p4_x2  <= p3_x2;
      p4_err <= p3_err;
      p5_p   <= p4_p;
      p5_t   <= p4_t;
      p5_s   <= bpc_pkg::sdiv_p2(p4_m3, 5'd16) + p4_x2 + 32'd3791;
      p5_err <= p4_err;
      // output register: zero both fields on a divide error
      temperature  <= p5_err ? 32'sd0 : $signed(p5_t);
      pressure     <= p5_err ? 32'sd0 : $signed(p5_p + bpc_pkg::sdiv_p2(p5_s, 5'd4));
      divide_error <= p5_err;
    end
  end

  assign out_v = v[5];

endmodule

FILE: sv/baro_pressure_compensation_unit.sv
// Barometer compensation pipeline: each input word (raw temperature, raw
// pressure sum and sample count) yields one output word with temperature in
// 0.1 degC, pressure in Pa and a divide_error flag (set, with both values
// zero, when X1+MD or B4 is zero). It takes one word per clock while not
// stalled and has 3 front stages, a 32-stage bit-per-stage divider for the
// temperature quotient (the pressure sum / count divide runs beside it), 10
// coefficient stages, a second 32-stage divider for the pressure quotient
// and 6 polynomial stages ending in the output register. The whole pipe
// advances together; a stalled output word holds every stage. Counts above
// 1024 are taken as 1024; a count of zero passes the sum through.
// Write calibration registers through cfg_we/cfg_index/cfg_data only while
// the pipe is empty; writes to indexes 5..7 are dropped.
module baro_pressure_compensation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        raw_temp,
  input  logic [25:0]        raw_pressure_sum,
  input  logic [10:0]        sample_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] temperature,
  output logic signed [31:0] pressure,
  output logic               divide_error
);

  logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;
  bpc_pkg::cal_t cal;

  logic adv;
  logic [2:0] v;

  logic [31:0] s1_p1;
  logic [25:0] s1_sum;
  logic [10:0] s1_cnt;
  logic [31:0] s2_x1;
  logic [25:0] s2_sum;
  logic [10:0] s2_cnt;
  logic [31:0] s3_num, s3_den, s3_usum, s3_ucnt;
  bpc_pkg::side_t s3_side;

  logic [31:0] den_s2;
  logic [31:0] num_s2;

  logic           d1_v;
  logic [31:0]    d1_q;
  bpc_pkg::side_t d1_side;
  logic [31:0]    du_q;

  logic           c_v;
  logic [31:0]    c_num, c_den;
  bpc_pkg::side_t c_side;

  logic           d2_v;
  logic [31:0]    d2_q;
  bpc_pkg::side_t d2_side;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac1_ac2 <= '0;
      cal_ac3_ac4 <= '0;
      cal_ac5_ac6 <= '0;
      cal_b1_b2   <= '0;
      cal_mc_md   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_AC1_AC2: cal_ac1_ac2 <= cfg_data;
        bpc_pkg::REG_AC3_AC4: cal_ac3_ac4 <= cfg_data;
        bpc_pkg::REG_AC5_AC6: cal_ac5_ac6 <= cfg_data;
        bpc_pkg::REG_B1_B2:   cal_b1_b2   <= cfg_data;
        bpc_pkg::REG_MC_MD:   cal_mc_md   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack into 32-bit words, signed ones sign-extended
  always_comb begin
    cal.ac1 = {{16{cal_ac1_ac2[31]}}, cal_ac1_ac2[31:16]};
    cal.ac2 = {{16{cal_ac1_ac2[15]}}, cal_ac1_ac2[15:0]};
    cal.ac3 = {{16{cal_ac3_ac4[31]}}, cal_ac3_ac4[31:16]};
    cal.ac4 = {16'd0, cal_ac3_ac4[15:0]};
    cal.ac5 = {16'd0, cal_ac5_ac6[31:16]};
    cal.ac6 = {16'd0, cal_ac5_ac6[15:0]};
    cal.b1  = {{16{cal_b1_b2[31]}}, cal_b1_b2[31:16]};
    cal.b2  = {{16{cal_b1_b2[15]}}, cal_b1_b2[15:0]};
    cal.mc  = {{16{cal_mc_md[31]}}, cal_mc_md[31:16]};
    cal.md  = {{16{cal_mc_md[15]}}, cal_mc_md[15:0]};
  end

  // Advance the whole pipe unless the output word is held
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[1:0], in_valid};
    end
  end

  assign den_s2 = s2_x1 + cal.md;
  assign num_s2 = {cal.mc[20:0], 11'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: (UT - AC6) * AC5, clamp the count
      s1_p1  <= ({16'd0, raw_temp} - cal.ac6) * cal.ac5;
      s1_sum <= raw_pressure_sum;
      s1_cnt <= (sample_count > bpc_pkg::MAX_SAMPLES) ? bpc_pkg::MAX_SAMPLES : sample_count;
      // stage 2: X1
      s2_x1  <= bpc_pkg::sdiv_p2(s1_p1, 5'd15);
      s2_sum <= s1_sum;
      s2_cnt <= s1_cnt;
      // stage 3: split the temperature divide into sign and magnitudes, set up the sum / count divide
      s3_num       <= bpc_pkg::mag(num_s2);
      s3_den       <= bpc_pkg::mag(den_s2);
      s3_side.val  <= s2_x1;
      s3_side.flag <= num_s2[31] ^ den_s2[31];
      s3_side.err  <= (den_s2 == 32'd0);
      s3_usum      <= {6'd0, s2_sum};
      s3_ucnt      <= (s2_cnt == 11'd0) ? 32'd1 : {21'd0, s2_cnt};
    end
  end

  bpc_div u_div_t (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_v     (v[2]),
    .num      (s3_num),
    .den      (s3_den),
    .side_in  (s3_side),
    .out_v    (d1_v),
    .quot     (d1_q),
    .side_out (d1_side)
  );

  bpc_div u_div_up (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_v     (v[2]),
    .num      (s3_usum),
    .den      (s3_ucnt),
    .side_in  ('0),
    .out_v    (),
    .quot     (du_q),
    .side_out ()
  );

  bpc_coef u_coef (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .cal   (cal),
    .in_v  (d1_v),
    .q1    (d1_q),
    .side1 (d1_side),
    .up    (du_q),
    .out_v (c_v),
    .num2  (c_num),
    .den2  (c_den),
    .side2 (c_side)
  );

  bpc_div u_div_p (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_v     (c_v),
    .num      (c_num),
    .den      (c_den),
    .side_in  (c_side),
    .out_v    (d2_v),
    .quot     (d2_q),
    .side_out (d2_side)
  );

  bpc_poly u_poly (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_v         (d2_v),
    .q2           (d2_q),
    .side2        (d2_side),
    .out_v        (out_valid),
    .temperature  (temperature),
    .pressure     (pressure),
    .divide_error (divide_error)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> temperature == 32'sd0 && pressure == 32'sd0)
    else $error("divide error with nonzero outputs");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressure) && $stable(temperature))
    else $error("held output word changed");

endmodule
